FILE: hw/rtl/ssm_pkg.sv
// Shared widths, register indexes and the cell link type for the substring
// match block. No dependencies; every other file imports this package.
`default_nettype none

package ssm_pkg;

	localparam int BYTE_W          = 8;
	localparam int PATTERN_BYTES_N = 8;
	localparam int PATTERN_W       = BYTE_W * PATTERN_BYTES_N;
	localparam int LENGTH_W        = 4;
	localparam int FIELD_W         = 16;
	localparam int CFG_INDEX_W     = 1;
	localparam int CFG_DATA_W      = PATTERN_W;
	localparam int SHIFT_W         = 7;

	localparam int PATTERN_MAX_DEF    = 8;
	localparam int POSITION_WIDTH_DEF = 16;

	localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(1);

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = CFG_INDEX_W'(1);

	// One window slot as it moves from cell to cell.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} ssm_link_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssm_text_if.sv
// Input channel of the substring match block: one text byte per item.
// Depends on ssm_pkg.
`default_nettype none

interface ssm_text_if;
	import ssm_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ssm_result_if.sv
// Result channel of the substring match block: one occurrence or text close.
// Depends on ssm_pkg.
`default_nettype none

interface ssm_result_if;
	import ssm_pkg::*;

	logic               valid;
	logic               ready;
	logic               match_found;
	logic [FIELD_W-1:0] match_start;
	logic [FIELD_W-1:0] match_end;
	logic [FIELD_W-1:0] match_count;
	logic               text_done;

	modport source (output valid, output match_found, output match_start,
		output match_end, output match_count, output text_done, input ready);
	modport sink (input valid, input match_found, input match_start,
		input match_end, input match_count, input text_done, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ssm_cell.sv
// One window cell: holds a text byte, compares the byte shifted into it
// against its expected pattern byte. Depends on ssm_pkg.
`default_nettype none

module ssm_cell (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       advance,
	input  wire                       flush,
	input  wire                       enable,
	input  wire [ssm_pkg::BYTE_W-1:0] exp_byte,
	input  ssm_pkg::ssm_link_t        link_in,
	output ssm_pkg::ssm_link_t        link_out,
	output logic                      hit
);
	import ssm_pkg::*;

	ssm_link_t slot_q;

	// Compare the incoming byte, i.e. this cell's contents after the shift.
	assign hit      = !enable || (link_in.valid && (link_in.data == exp_byte));
	assign link_out = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (advance) begin
			if (flush) begin
				slot_q <= '0;
			end else begin
				slot_q <= link_in;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/substring_match_positions.sv
// Streaming substring search over a chain of window cells.
// Output: a result is registered on the clock edge that accepts its text item.
// Throughput: one text item per cycle unless the output register stalls; the cell
// chain compares all bytes in parallel; the output stalls only on result.ready.
// Reset: pattern clears to zero, length to one, window/position/count to zero.
`default_nettype none

module substring_match_positions #(
	parameter int PATTERN_MAX    = ssm_pkg::PATTERN_MAX_DEF,
	parameter int POSITION_WIDTH = ssm_pkg::POSITION_WIDTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_write,
	input  wire [ssm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [ssm_pkg::CFG_DATA_W-1:0]  cfg_data,
	ssm_text_if.sink                       text,
	ssm_result_if.source                   result
);
	import ssm_pkg::*;

	// Configuration registers.
	logic [PATTERN_W-1:0] pattern_q;
	logic [LENGTH_W-1:0]  length_q;

	// Text state: cells hold the window, these hold position and count.
	logic [POSITION_WIDTH-1:0] pos_q;
	logic [FIELD_W-1:0]        count_q;

	// Output register.
	logic               res_valid_s1;
	logic               match_found_s1;
	logic [FIELD_W-1:0] match_start_s1;
	logic [FIELD_W-1:0] match_end_s1;
	logic [FIELD_W-1:0] match_count_s1;
	logic               text_done_s1;

	logic                      in_fire;
	logic                      length_ok;
	logic                      match;
	logic [PATTERN_W-1:0]      pattern_rev;
	logic [PATTERN_W-1:0]      exp_vec;
	logic [SHIFT_W-1:0]        shift_amt;
	logic [PATTERN_MAX-1:0]    hit_vec;
	ssm_link_t                 head_link;
	ssm_link_t                 cell_out [PATTERN_MAX];
	logic [POSITION_WIDTH-1:0] pos_next;
	logic [POSITION_WIDTH-1:0] start_pos;
	logic [FIELD_W-1:0]        count_next;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= LENGTH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_BYTES:  pattern_q <= cfg_data;
				REG_PATTERN_LENGTH: length_q  <= cfg_data[LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Cell k compares against pattern byte (length-1-k). Reverse the pattern
	// bytes, then shift right by (8 - length) bytes so that byte k lines up.
	for (genvar j = 0; j < PATTERN_BYTES_N; j++) begin : g_rev
		assign pattern_rev[j*BYTE_W +: BYTE_W] =
			pattern_q[(PATTERN_BYTES_N-1-j)*BYTE_W +: BYTE_W];
	end

	assign shift_amt = SHIFT_W'({4'(LENGTH_W'(PATTERN_BYTES_N) - length_q), 3'b000});
	assign exp_vec   = pattern_rev >> shift_amt;

	// Zero length and lengths past the window never match.
	assign length_ok = (length_q != '0) && (32'(length_q) <= PATTERN_MAX);

	assign in_fire   = text.valid && text.ready;
	assign head_link = '{valid: 1'b1, data: text.text_byte};

	// The window: cell 0 takes the new byte, each cell hands its byte on.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		ssm_link_t link_in_k;
		logic      enable_k;

		if (k == 0) begin : g_head
			assign link_in_k = head_link;
		end else begin : g_body
			assign link_in_k = cell_out[k-1];
		end

		assign enable_k = length_ok && (32'(length_q) > k);

		ssm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (in_fire),
			.flush    (text.last_byte),
			.enable   (enable_k),
			.exp_byte (exp_vec[k*BYTE_W +: BYTE_W]),
			.link_in  (link_in_k),
			.link_out (cell_out[k]),
			.hit      (hit_vec[k])
		);
	end

	assign match = length_ok && (&hit_vec);

	// Saturating position and count.
	assign pos_next   = (pos_q == '1) ? pos_q : pos_q + 1'b1;
	assign start_pos  = pos_next - (POSITION_WIDTH'(length_q) - 1'b1);
	assign count_next = (match && (count_q != '1)) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
		end else if (in_fire) begin
			if (text.last_byte) begin
				pos_q   <= '0;
				count_q <= '0;
			end else begin
				pos_q   <= pos_next;
				count_q <= count_next;
			end
		end
	end

	// Take a new item whenever the output register is empty or draining.
	assign text.ready = !res_valid_s1 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1   <= 1'b0;
			match_found_s1 <= 1'b0;
			match_start_s1 <= '0;
			match_end_s1   <= '0;
			match_count_s1 <= '0;
			text_done_s1   <= 1'b0;
		end else if (text.ready) begin
			// Load a result on a match or on the closing byte; else drop.
			res_valid_s1 <= in_fire && (match || text.last_byte);
			if (in_fire) begin
				match_found_s1 <= match;
				match_start_s1 <= match ? FIELD_W'(start_pos) : '0;
				match_end_s1   <= match ? FIELD_W'(pos_next) : '0;
				match_count_s1 <= count_next;
				text_done_s1   <= text.last_byte;
			end
		end
	end

	assign result.valid       = res_valid_s1;
	assign result.match_found = match_found_s1;
	assign result.match_start = match_start_s1;
	assign result.match_end   = match_end_s1;
	assign result.match_count = match_count_s1;
	assign result.text_done   = text_done_s1;

	// A result without a match only ever closes a text.
	a_nomatch_closes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && !match_found_s1 |-> text_done_s1)
		else $error("result with neither match nor text close");

	// Positions are zero unless a match is reported.
	a_nomatch_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && !match_found_s1 |-> (match_start_s1 == '0) && (match_end_s1 == '0))
		else $error("positions set without a match");

	// A reported match always carries a nonzero count.
	a_match_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && match_found_s1 |-> (match_count_s1 != '0))
		else $error("match reported with zero count");

	// The closing byte clears position and count for the next text.
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && text.last_byte |=> (pos_q == '0) && (count_q == '0))
		else $error("text state not cleared after last byte");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for substring_match_positions: streams text bytes, predicts
// every occurrence and text close in a local scan model, and checks each result.
// Depends on ssm_pkg, ssm_text_if, ssm_result_if and the block itself.

module testbench;
	import ssm_pkg::*;

	localparam int WIN_N = PATTERN_MAX_DEF;
	localparam logic [FIELD_W-1:0] POS_MAX = {FIELD_W{1'b1}};
	localparam logic [FIELD_W-1:0] COUNT_MAX = {FIELD_W{1'b1}};
	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_STALL = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTING_ITEMS = 75;
	localparam int SETTINGS_PER_PHASE = 4;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              closes;
	} text_item_t;

	typedef struct packed {
		logic               found;
		logic [FIELD_W-1:0] first_pos;
		logic [FIELD_W-1:0] last_pos;
		logic [FIELD_W-1:0] count;
		logic               done;
	} match_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Driven copies of the channel controls, so every input is known from time zero.
	logic send_valid = 1'b0;
	logic [BYTE_W-1:0] send_value = '0;
	logic send_closes = 1'b0;
	logic take_ready = 1'b0;

	logic stall_kick = 1'b0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	int unsigned errors = 0;
	idle_mode_t idle_mode = IDLE_NONE;

	text_item_t text_backlog[$];
	match_report_t pending_reports[$];

	// Scan model: configuration copy and per-text state.
	logic [PATTERN_W-1:0] pat_bytes;
	logic [LENGTH_W-1:0] pat_len;
	logic [BYTE_W-1:0] recent [WIN_N];
	int unsigned fill;
	logic [FIELD_W-1:0] position;
	logic [FIELD_W-1:0] total;

	ssm_text_if text_ch ();
	ssm_result_if result_ch ();

	assign text_ch.valid = send_valid;
	assign text_ch.text_byte = send_value;
	assign text_ch.last_byte = send_closes;
	assign result_ch.ready = take_ready;

	substring_match_positions i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.text     (text_ch.sink),
		.result   (result_ch.source)
	);

	always #10 clk = ~clk;

	// Watchdog: end the run if the stream never drains.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[substring_match_positions] ERROR");
			$finish;
		end
	end

	// Drop all per-text state; the window restarts empty at position zero.
	task automatic clear_text();
		for (int i = 0; i < WIN_N; i++)
			recent[i] = '0;
		fill = 0;
		position = '0;
		total = '0;
	endtask

	// Shift one accepted byte into the window and queue the result it causes, if any.
	task automatic scan_byte(input logic [BYTE_W-1:0] value, input logic closes);
		match_report_t rep;
		logic hit;
		int unsigned n;
		for (int i = WIN_N - 1; i > 0; i--)
			recent[i] = recent[i-1];
		recent[0] = value;
		if (fill < WIN_N)
			fill++;
		if (position != POS_MAX)
			position++;
		n = 32'(pat_len);
		// zero and overlong lengths never match; the window must hold n bytes
		hit = (n != 0) && (n <= WIN_N) && (fill >= n);
		for (int i = 0; i < WIN_N; i++)
			if (hit && i < n && recent[n-1-i] != pat_bytes[8*i +: 8])
				hit = 1'b0;
		if (hit && total != COUNT_MAX)
			total++;
		if (hit || closes) begin
			rep.found = hit;
			rep.first_pos = hit ? position - FIELD_W'(n - 1) : '0;
			rep.last_pos = hit ? position : '0;
			rep.count = total;
			rep.done = closes;
			pending_reports.push_back(rep);
		end
		if (closes)
			clear_text();
	endtask

	function automatic logic sender_rests();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < 52;
			IDLE_BOTH: return $urandom_range(99) < 16;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_rests();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(99) < 52;
			IDLE_BOTH: return $urandom_range(99) < 16;
			default:   return 1'b0;
		endcase
	endfunction

	// Text sender: hold an offered item until it is taken, then advance to the next.
	always @(posedge clk) begin : drive_text
		text_item_t nxt;
		if (!arst_n) begin
			send_valid <= 1'b0;
		end else begin
			if (send_valid && text_ch.ready)
				scan_byte(send_value, send_closes);
			if (!send_valid || text_ch.ready) begin
				if (text_backlog.size() != 0 && !sender_rests()) begin
					nxt = text_backlog.pop_front();
					send_valid <= 1'b1;
					send_value <= nxt.value;
					send_closes <= nxt.closes;
				end else begin
					send_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted down on its own.
	always @(posedge clk) begin
		if (!arst_n)
			stall_left <= 0;
		else if (stall_kick)
			stall_left <= LONG_STALL;
		else if (stall_left != 0)
			stall_left <= stall_left - 1;
	end

	task automatic flag_field(input string field, input logic [FIELD_W-1:0] want,
		input logic [FIELD_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	task automatic check_report(input match_report_t got);
		match_report_t want;
		if (pending_reports.size() == 0) begin
			errors++;
			$display("%0t: result with nothing expected: got %p", $time, got);
		end else begin
			want = pending_reports.pop_front();
			flag_field("match_found", FIELD_W'(want.found), FIELD_W'(got.found));
			flag_field("match_start", want.first_pos, got.first_pos);
			flag_field("match_end", want.last_pos, got.last_pos);
			flag_field("match_count", want.count, got.count);
			flag_field("text_done", FIELD_W'(want.done), FIELD_W'(got.done));
		end
	endtask

	// Result receiver: check every taken result against the oldest prediction.
	always @(posedge clk) begin : watch_result
		match_report_t got;
		if (!arst_n) begin
			take_ready <= 1'b0;
		end else begin
			if (result_ch.valid && take_ready) begin
				got.found = result_ch.match_found;
				got.first_pos = result_ch.match_start;
				got.last_pos = result_ch.match_end;
				got.count = result_ch.match_count;
				got.done = result_ch.text_done;
				check_report(got);
			end
			take_ready <= (stall_left == 0) && !receiver_rests();
		end
	end

	task automatic push_text(input logic [BYTE_W-1:0] value, input logic closes);
		text_item_t it;
		it.value = value;
		it.closes = closes;
		text_backlog.push_back(it);
	endtask

	// Wait until every item is taken and every result is in, then wait out the
	// DRAIN_CYCLES drain.
	task automatic settle();
		while (text_backlog.size() != 0 || send_valid || pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_PATTERN_BYTES)
			pat_bytes = val;
		else
			pat_len = val[LENGTH_W-1:0];
	endtask

	// One random setting: a pattern over a small alphabet, then texts made
	// mostly of pattern copies (some cut short) and alphabet bytes, plus noise.
	task automatic run_setting(input int unsigned budget);
		logic [BYTE_W-1:0] alpha [3];
		logic [CFG_DATA_W-1:0] pat;
		logic [LENGTH_W-1:0] len;
		logic [BYTE_W-1:0] b;
		int unsigned pick, span, copy_at, tlen, queued;
		logic noise;
		for (int i = 0; i < 3; i++)
			alpha[i] = BYTE_W'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 5)
			len = '0;
		else if (pick < 10)
			len = LENGTH_W'($urandom_range(15, 9));
		else
			len = LENGTH_W'($urandom_range(8, 1));
		pat = {$urandom, $urandom};
		for (int i = 0; i < WIN_N; i++)
			if ($urandom_range(3) != 0)
				pat[8*i +: 8] = alpha[$urandom_range(2)];
		settle();
		write_reg(REG_PATTERN_BYTES, pat);
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
		span = (len > WIN_N) ? WIN_N : 32'(len);
		queued = 0;
		while (queued < budget) begin
			tlen = $urandom_range(40, 1);
			noise = ($urandom_range(9) == 0);
			copy_at = span;
			for (int k = 0; k < tlen; k++) begin
				if (noise) begin
					b = BYTE_W'($urandom_range(255));
				end else if (copy_at < span) begin
					b = pat[8*copy_at +: 8];
					copy_at++;
					// break off a copy now and then
					if ($urandom_range(19) == 0)
						copy_at = span;
				end else if (span != 0 && $urandom_range(2) == 0) begin
					b = pat[7:0];
					copy_at = 1;
				end else begin
					b = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) :
						alpha[$urandom_range(2)];
				end
				push_text(b, k == tlen - 1);
				queued++;
			end
		end
	endtask

	initial begin
		pat_bytes = '0;
		pat_len = LENGTH_RESET;
		clear_text();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting: zero pattern byte, length one, so each zero byte matches.
		push_text(8'h00, 1'b0);
		push_text(8'hFF, 1'b0);
		push_text(8'h00, 1'b1);

		// Overlapping occurrences of a three-byte pattern; upper bytes are junk.
		settle();
		write_reg(REG_PATTERN_BYTES, 64'hDEAD_BEEF_0061_6261);
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(3));
		push_text(8'h61, 1'b0);
		push_text(8'h62, 1'b0);
		push_text(8'h61, 1'b0);
		push_text(8'h62, 1'b0);
		push_text(8'h61, 1'b1);

		// Zero length never matches; only the close comes out.
		settle();
		write_reg(REG_PATTERN_LENGTH, '0);
		push_text(8'h61, 1'b0);
		push_text(8'h61, 1'b1);

		// Full-width pattern of all-ones bytes, matched on the closing byte.
		settle();
		write_reg(REG_PATTERN_BYTES, {CFG_DATA_W{1'b1}});
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(8));
		for (int k = 0; k < 8; k++)
			push_text(8'hFF, k == 7);

		// Length above the window never matches.
		settle();
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(15));
		for (int k = 0; k < 3; k++)
			push_text(8'hFF, k == 2);

		// Back-pressure: every byte matches while the receiver holds off, so the
		// result register fills and the block must stall its text input.
		settle();
		write_reg(REG_PATTERN_BYTES, CFG_DATA_W'(8'h61));
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(1));
		for (int k = 0; k < 64; k++)
			push_text(8'h61, k == 63);
		@(posedge clk);
		stall_kick <= 1'b1;
		@(posedge clk);
		stall_kick <= 1'b0;

		// Random settings under each idling pattern; settle() between settings
		// makes the sender pause until every result is in.
		for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
			settle();
			idle_mode = idle_mode_t'(m);
			for (int s = 0; s < SETTINGS_PER_PHASE; s++)
				run_setting(SETTING_ITEMS);
		end

		settle();
		if (errors == 0 && pending_reports.size() == 0)
			$display("[substring_match_positions] OK");
		else
			$display("[substring_match_positions] ERROR");
		$finish;
	end

endmodule
